// ===== rtl/cpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell pair face agglomerator package
// Fixed field widths and stream packing constants shared by the block.
// ----------------------------------------------------------------------------
package cpfa_pkg;

  // Widths of the item fields on the stream ports.
  localparam int unsigned CellW       = 16;
  localparam int unsigned CoarseFaceW = 10;
  localparam int unsigned FaceCellW   = 16;

  // Packed stream widths; the tdata widths are whole bytes.
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned InTuserW  = 1;
  localparam int unsigned OutTdataW = 32;
  localparam int unsigned OutTuserW = 2;

  // Bit positions inside the packed words.
  localparam int unsigned InNeighLo     = CellW;
  localparam int unsigned OutFaceCellLo = CoarseFaceW;
  localparam int unsigned OutPadW       = OutTdataW - CoarseFaceW - FaceCellW;

  // Result flags carried on the output side.
  typedef struct packed {
    logic overflow;
    logic is_new;
  } res_flags_t;

endpackage : cpfa_pkg

// ===== rtl/cell_pair_face_agglomerator.sv =====
// ----------------------------------------------------------------------------
// Cell pair face agglomerator
// Maps fine faces, given as coarse cell pairs, onto dense coarse face numbers.
// ----------------------------------------------------------------------------
// Each input item is one fine face (local and neighbour coarse cell). The pair
// is ordered by owner_side and searched for among the pairs stored since the
// last first_face, one table entry at a time through the single read port of
// the key memory and one shared comparator, each entry being read and then
// compared. A face matching stored entry h stops the scan at that entry; an
// unseen face scans all N stored entries (none when the table is empty). The
// input is ready again at the edge that the result reaches the output, or
// later while a previous result still waits there. One item is handled at a
// time; the output register holds a finished result while the next item is
// taken. No clearing pass is needed after reset: the coarse face count marks
// which entries are in use, and first_face simply sets it back to zero.
// ----------------------------------------------------------------------------
module cell_pair_face_agglomerator #(
  parameter int unsigned TABLE_DEPTH  = 1024,
  parameter int unsigned CELL_ID_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: owner_side register.
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  // Input items.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: local_cell [15:0], neighbour_cell [31:16].
  input  logic [cpfa_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // tuser: first_face [0].
  input  logic [cpfa_pkg::InTuserW-1:0]  s_axis_tuser_i,
  // Result items.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: coarse_face [9:0], face_cell [25:10], zero padding [31:26].
  output logic [cpfa_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // tuser: is_new [0], overflow [1].
  output logic [cpfa_pkg::OutTuserW-1:0] m_axis_tuser_o
);

  localparam int unsigned KeyW = 2 * CELL_ID_BITS;
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_e;

  state_e                           state_q;
  logic                             owner_q;
  logic [KeyW-1:0]                  key_q;
  logic [cpfa_pkg::CellW-1:0]       local_q;
  logic [CntW-1:0]                  count_q;
  logic [IdxW-1:0]                  scan_idx_q;
  logic [KeyW-1:0]                  rd_data_q;
  logic [cpfa_pkg::CoarseFaceW-1:0] res_face_q;
  logic [cpfa_pkg::FaceCellW-1:0]   res_cell_q;
  cpfa_pkg::res_flags_t             res_flags_q;
  logic                             m_valid_q;
  logic [cpfa_pkg::CoarseFaceW-1:0] m_face_q;
  logic [cpfa_pkg::FaceCellW-1:0]   m_cell_q;
  cpfa_pkg::res_flags_t             m_flags_q;

  logic [KeyW-1:0]                  key_mem [TABLE_DEPTH];

  logic                             in_accept;
  logic [cpfa_pkg::CellW-1:0]       in_local;
  logic [cpfa_pkg::CellW-1:0]       in_neigh;
  logic [CELL_ID_BITS-1:0]          first_cell;
  logic [CELL_ID_BITS-1:0]          second_cell;
  logic [KeyW-1:0]                  key_d;
  logic                             hit;
  logic                             scan_end;
  logic                             miss;
  logic                             table_full;
  logic                             mem_we;
  logic                             out_free;

  // Input unpacking and key ordering.
  assign in_local    = s_axis_tdata_i[cpfa_pkg::CellW-1:0];
  assign in_neigh    = s_axis_tdata_i[cpfa_pkg::InNeighLo +: cpfa_pkg::CellW];
  assign first_cell  = owner_q ? CELL_ID_BITS'(in_local) : CELL_ID_BITS'(in_neigh);
  assign second_cell = owner_q ? CELL_ID_BITS'(in_neigh) : CELL_ID_BITS'(in_local);
  assign key_d       = {first_cell, second_cell};

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // Shared comparator and scan control.
  always_comb begin
    hit        = (state_q == S_CMP) && (rd_data_q == key_q);
    scan_end   = (CntW'(scan_idx_q) + CntW'(1)) == count_q;
    miss       = ((state_q == S_READ) && (count_q == '0)) ||
                 ((state_q == S_CMP) && !hit && scan_end);
    table_full = (count_q == CntW'(TABLE_DEPTH));
    mem_we     = miss && !table_full;
  end

  // Key memory: one write port for inserts, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[count_q[IdxW-1:0]] <= key_q;
    end
    rd_data_q <= key_mem[scan_idx_q];
  end

  // Sequencer, configuration register and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      owner_q     <= 1'b1;
      count_q     <= '0;
      scan_idx_q  <= '0;
      m_valid_q   <= 1'b0;
      key_q       <= '0;
      local_q     <= '0;
      res_face_q  <= '0;
      res_cell_q  <= '0;
      res_flags_q <= '0;
      m_face_q    <= '0;
      m_cell_q    <= '0;
      m_flags_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        owner_q <= cfg_wdata_i;
      end
      // In S_DONE the output register is refilled whenever it is taken.
      if (m_axis_tready_i && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            key_q      <= key_d;
            local_q    <= in_local;
            scan_idx_q <= '0;
            if (s_axis_tuser_i[0]) begin
              count_q <= '0;
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (count_q != '0) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            res_face_q  <= cpfa_pkg::CoarseFaceW'(scan_idx_q);
            res_cell_q  <= '0;
            res_flags_q <= '0;
            state_q     <= S_DONE;
          end else if (!scan_end) begin
            scan_idx_q <= scan_idx_q + IdxW'(1);
            state_q    <= S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_face_q  <= res_face_q;
            m_cell_q  <= res_cell_q;
            m_flags_q <= res_flags_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // An unseen pair either claims the next coarse face or overflows.
      if (miss) begin
        state_q <= S_DONE;
        if (table_full) begin
          res_face_q           <= '0;
          res_cell_q           <= '0;
          res_flags_q.is_new   <= 1'b0;
          res_flags_q.overflow <= 1'b1;
        end else begin
          res_face_q           <= cpfa_pkg::CoarseFaceW'(count_q);
          res_cell_q           <= local_q;
          res_flags_q.is_new   <= 1'b1;
          res_flags_q.overflow <= 1'b0;
          count_q              <= count_q + CntW'(1);
        end
      end
    end
  end

  // Output packing.
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{cpfa_pkg::OutPadW{1'b0}}, m_cell_q, m_face_q};
  assign m_axis_tuser_o  = m_flags_q;

  // Checks on the table bookkeeping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
  else $error("coarse face count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(m_flags_q.is_new && m_flags_q.overflow))
  else $error("result is both new and overflowed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_flags_q.is_new) |->
      (res_face_q == cpfa_pkg::CoarseFaceW'(count_q - CntW'(1))))
  else $error("new coarse face number does not match the count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (count_q != '0))
  else $error("insert did not advance the coarse face count");

endmodule : cell_pair_face_agglomerator
